// ----- sv/mst_pkg.sv -----
package mst_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_RESULTS   = 32;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [4:0] EV_SYN         = 5'd0;
  localparam logic [4:0] EV_ABS         = 5'd3;
  localparam logic [9:0] CODE_REPORT    = 10'h000;
  localparam logic [9:0] CODE_SLOT      = 10'h02f;
  localparam logic [9:0] CODE_POS_X     = 10'h035;
  localparam logic [9:0] CODE_POS_Y     = 10'h036;
  localparam logic [9:0] CODE_FINGER_ID = 10'h039;

  typedef enum logic [1:0] {
    KIND_BEGAN = 2'd0,
    KIND_MOVED = 2'd1,
    KIND_ENDED = 2'd2
  } touch_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_EVAL,
    ST_BEGAN,
    ST_FLUSH
  } mst_state_t;

  typedef struct packed {
    logic [4:0]         device_num;
    logic [4:0]         ev_type;
    logic [9:0]         ev_code;
    logic signed [31:0] ev_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         touch_kind;
    logic [30:0]        finger;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               last;
  } out_item_t;

  // one memory word per slot
  typedef struct packed {
    logic               now_ok;
    logic [30:0]        now_id;
    logic               before_ok;
    logic [30:0]        before_id;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } slot_entry_t;

  // sequencer to output stage
  typedef struct packed {
    logic      push;
    logic      flush;
    out_item_t item;
  } out_ctl_t;

endpackage

// ----- sv/mst_slot_mem.sv -----
module mst_slot_mem
  import mst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  slot_entry_t       wr_data
);

  slot_entry_t mem [NUM_SLOTS];
  logic        valid_r [NUM_SLOTS];
  slot_entry_t rd_data_r;

  // entries never written read as empty slots at the origin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) valid_r[i] <= 1'b0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/mst_out_stage.sv -----
module mst_out_stage
  import mst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  out_ctl_t  ctl,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      hold_v_r, hold_v_nxt;
  out_item_t hold_r, hold_nxt;
  logic      out_v_r, out_v_nxt;
  out_item_t out_r, out_nxt;

  // one result is held back until the next one (or the end of the report) decides last
  assign room = !hold_v_r || !out_v_r || out_ready;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    if (out_v_r && out_ready) out_v_nxt = 1'b0;
    if (ctl.push) begin
      if (hold_v_r) begin
        out_nxt      = hold_r;
        out_nxt.last = 1'b0;
        out_v_nxt    = 1'b1;
      end
      hold_nxt   = ctl.item;
      hold_v_nxt = 1'b1;
    end else if (ctl.flush && hold_v_r) begin
      out_nxt      = hold_r;
      out_nxt.last = 1'b1;
      out_v_nxt    = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

// ----- sv/mst_seq.sv -----
module mst_seq
  import mst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              rd_en,
  output logic [SLOT_W-1:0] rd_addr,
  input  slot_entry_t       rd_data,
  output logic              wr_en,
  output logic [SLOT_W-1:0] wr_addr,
  output slot_entry_t       wr_data,
  output out_ctl_t          ctl,
  input  logic              room
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  mst_state_t         state_r, state_nxt;
  logic [SLOT_W-1:0]  sel_r, sel_nxt;
  logic               sel_ok_r, sel_ok_nxt;
  logic               seen_r, seen_nxt;
  logic [4:0]         dev_r, dev_nxt;
  logic [9:0]         code_r, code_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [SLOT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;

  logic [31:0]  in_val_u;
  logic         same;
  logic         can_emit;
  slot_entry_t  e;
  slot_entry_t  upd;

  assign e        = rd_data;
  assign in_val_u = in_item.ev_value;
  assign same     = (e.before_ok == e.now_ok) && (!e.now_ok || e.before_id == e.now_id);
  assign can_emit = n_r < CNT_W'(MAX_RESULTS);
  assign in_ready = (state_r == ST_IDLE);

  // absolute-axis update of the selected slot
  always_comb begin
    upd = e;
    case (code_r)
      CODE_FINGER_ID: begin
        upd.now_ok = !val_r[31];
        upd.now_id = val_r[31] ? 31'd0 : val_r[30:0];
      end
      CODE_POS_X: upd.x = val_r;
      CODE_POS_Y: upd.y = val_r;
      default: upd = e;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    sel_ok_nxt = sel_ok_r;
    seen_nxt   = seen_r;
    dev_nxt    = dev_r;
    code_nxt   = code_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    rd_en      = 1'b0;
    rd_addr    = sel_r;
    wr_en      = 1'b0;
    wr_addr    = cnt_r;
    wr_data    = e;
    ctl        = '0;
    ctl.item.touch_kind = KIND_MOVED;
    ctl.item.finger     = e.now_id;
    ctl.item.pos_x      = e.x;
    ctl.item.pos_y      = e.y;
    ctl.item.last       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.ev_type == EV_ABS) begin
            case (in_item.ev_code)
              CODE_SLOT: begin
                seen_nxt = 1'b1;
                dev_nxt  = in_item.device_num;
                if (!in_val_u[31] && in_val_u < 32'(NUM_SLOTS)) begin
                  sel_nxt    = in_val_u[SLOT_W-1:0];
                  sel_ok_nxt = 1'b1;
                end else begin
                  sel_ok_nxt = 1'b0;
                end
              end
              CODE_FINGER_ID, CODE_POS_X, CODE_POS_Y: begin
                seen_nxt = 1'b1;
                dev_nxt  = in_item.device_num;
                if (sel_ok_r) begin
                  rd_en     = 1'b1;
                  rd_addr   = sel_r;
                  code_nxt  = in_item.ev_code;
                  val_nxt   = in_item.ev_value;
                  state_nxt = ST_WRITE;
                end
              end
              default: state_nxt = ST_IDLE;
            endcase
          end else if (in_item.ev_type == EV_SYN && in_item.ev_code == CODE_REPORT &&
                       seen_r && in_item.device_num == dev_r) begin
            cnt_nxt   = '0;
            n_nxt     = '0;
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = ST_EVAL;
          end
        end
      end

      ST_WRITE: begin
        wr_en     = 1'b1;
        wr_addr   = sel_r;
        wr_data   = upd;
        state_nxt = ST_IDLE;
      end

      ST_EVAL: begin
        if (same) begin
          if (!(e.now_ok && can_emit) || room) begin
            if (e.now_ok && can_emit) begin
              ctl.push = 1'b1;
              n_nxt    = n_r + CNT_W'(1);
            end
            if (cnt_r == LAST_SLOT) begin
              state_nxt = ST_FLUSH;
            end else begin
              cnt_nxt = cnt_r + SLOT_W'(1);
              rd_en   = 1'b1;
              rd_addr = cnt_r + SLOT_W'(1);
            end
          end
        end else if (!e.before_ok) begin
          state_nxt = ST_BEGAN;
        end else if (!can_emit || room) begin
          if (can_emit) begin
            ctl.push            = 1'b1;
            ctl.item.touch_kind = KIND_ENDED;
            ctl.item.finger     = e.before_id;
            n_nxt               = n_r + CNT_W'(1);
          end
          if (e.now_ok) begin
            state_nxt = ST_BEGAN;
          end else begin
            wr_en             = 1'b1;
            wr_data.before_ok = e.now_ok;
            wr_data.before_id = e.now_id;
            if (cnt_r == LAST_SLOT) begin
              state_nxt = ST_FLUSH;
            end else begin
              cnt_nxt = cnt_r + SLOT_W'(1);
              rd_en   = 1'b1;
              rd_addr = cnt_r + SLOT_W'(1);
            end
          end
        end
      end

      ST_BEGAN: begin
        if (!can_emit || room) begin
          if (can_emit) begin
            ctl.push            = 1'b1;
            ctl.item.touch_kind = KIND_BEGAN;
            n_nxt               = n_r + CNT_W'(1);
          end
          wr_en             = 1'b1;
          wr_data.before_ok = e.now_ok;
          wr_data.before_id = e.now_id;
          if (cnt_r == LAST_SLOT) begin
            state_nxt = ST_FLUSH;
          end else begin
            cnt_nxt   = cnt_r + SLOT_W'(1);
            rd_en     = 1'b1;
            rd_addr   = cnt_r + SLOT_W'(1);
            state_nxt = ST_EVAL;
          end
        end
      end

      ST_FLUSH: begin
        if (room) begin
          ctl.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      sel_r    <= '0;
      sel_ok_r <= 1'b1;
      seen_r   <= 1'b0;
      dev_r    <= '0;
      cnt_r    <= '0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      sel_r    <= sel_nxt;
      sel_ok_r <= sel_ok_nxt;
      seen_r   <= seen_nxt;
      dev_r    <= dev_nxt;
      cnt_r    <= cnt_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    val_r  <= val_nxt;
  end

endmodule

// ----- sv/multitouch_slot_tracker_core.sv -----
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_ready   | in_item (mst_pkg::in_item_t)
// out_     | output    | out_valid / out_ready | out_item (mst_pkg::out_item_t)
//
// select, ignored event or write behind an out-of-range select: handled in ST_IDLE alone;
// id or coordinate: read in ST_IDLE, written in ST_WRITE; sync report: one slot a cycle
// over separate read and write ports, slowed by a stall or a slot whose id turns present
// reset: synchronous, active low; slot memory clears at once through per-slot valid bits
// a stalled result stalls the report walk; the last finished result waits in the output
// register while the next item is taken
module multitouch_slot_tracker_core
  import mst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // slot address width, one bit minimum
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // slot memory port
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  slot_entry_t       rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_entry_t       wr_data;

  // sequencer to output stage
  out_ctl_t ctl;
  logic     room;

  // per-slot state: current and previous finger id plus coordinates, one word a slot
  mst_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // decodes events, does read-modify-write of slot words and walks the slots on a report
  mst_seq #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .ctl      (ctl),
    .room     (room)
  );

  // holds one result back to mark the final item of a report, then registers it out
  mst_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
